// ===== hw/rtl/ssg_pkg.sv =====
package ssg_pkg;

  // segment table geometry
  localparam int unsigned MaxSegments = 16;
  localparam int unsigned IdxW        = $clog2(MaxSegments);
  localparam int unsigned CntW        = 5;

  // raised cosine table
  localparam int unsigned CosN    = 256;
  localparam int unsigned CosLog2 = $clog2(CosN);
  localparam int unsigned CosIdxW = CosLog2 + 1;

  localparam logic [16:0] OneQ16 = 17'h10000;

  // operation codes
  localparam logic [1:0] OpLoad    = 2'd0;
  localparam logic [1:0] OpRestart = 2'd1;
  localparam logic [1:0] OpAdvance = 2'd2;

  // shape codes
  localparam logic [1:0] ShapeStep   = 2'd0;
  localparam logic [1:0] ShapeLinear = 2'd1;
  localparam logic [1:0] ShapeSmooth = 2'd2;
  localparam logic [1:0] ShapeCosine = 2'd3;

  localparam longint unsigned OneQ30 = 64'd1073741824;
  localparam longint unsigned PiQ30  = 64'd3373259426;

  typedef logic [16:0] cos_rom_t [CosN+1];

  // shift and subtract long division, elaboration only
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // cosine by eleven taylor terms in q30, elaboration only
  function automatic longint cos_q30(longint unsigned t);
    longint unsigned t2;
    longint unsigned term;
    longint          sum;
    t2   = (t * t) >> 30;
    term = OneQ30;
    sum  = longint'(OneQ30);
    for (int k = 1; k <= 10; k++) begin
      term = udiv64((term * t2) >> 30, longint'((2 * k - 1) * (2 * k)));
      if ((k & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

  // (1 - cos(pi i/n))/2 in q16, clamped and nondecreasing
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t        r;
    longint unsigned a;
    longint          c;
    longint          v;
    longint unsigned f;
    for (int i = 0; i <= CosN; i++) begin
      a = (longint'(i) * PiQ30 + (CosN >> 1)) >> CosLog2;
      if (a > PiQ30) a = PiQ30;
      if (2 * a <= PiQ30) c = cos_q30(a);
      else c = -cos_q30(PiQ30 - a);
      v = longint'(OneQ30) - c;
      if (v < 0) v = 0;
      if (v > 2 * longint'(OneQ30)) v = 2 * longint'(OneQ30);
      f = (longint'(v) + 16384) >> 15;
      if (f > 65536) f = 65536;
      if (i > 0 && f < longint'(r[i-1])) f = longint'(r[i-1]);
      r[i] = f[16:0];
    end
    return r;
  endfunction

  localparam cos_rom_t CosRom = build_cos_rom();

endpackage

// ===== hw/rtl/segmented_speed_profile_generator.sv =====
// Speed setpoint sequencer over a 16-entry segment table. Every beat in
// (load, restart or advance) returns one beat out with the setpoint, the
// finished flag and the active index; the block takes no new beat until the
// result beat has been taken. A load or restart evaluates the active segment;
// an advance first walks forward one segment at a time past every segment
// its step finishes. Cost is set by the bit-serial progress divider and the
// single shared 33x18 multiplier, which smoothstep uses twice, raised cosine
// interpolation once, and every shaped speed once more.
module segmented_speed_profile_generator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [3:0]         slot_i,
  input  logic signed [31:0] start_speed_i,
  input  logic signed [31:0] target_speed_i,
  input  logic [31:0]        span_length_i,
  input  logic [1:0]         shape_code_i,
  input  logic               distance_based_i,
  input  logic signed [31:0] time_step_i,
  input  logic signed [31:0] distance_step_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] speed_out_o,
  output logic               finished_o,
  output logic [4:0]         segment_index_o
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SWalk  = 4'd1;
  localparam logic [3:0] SEval  = 4'd2;
  localparam logic [3:0] SDiv   = 4'd3;
  localparam logic [3:0] SShape = 4'd4;
  localparam logic [3:0] SMul   = 4'd5;
  localparam logic [3:0] SSm1   = 4'd6;
  localparam logic [3:0] SSm2   = 4'd7;
  localparam logic [3:0] SCos   = 4'd8;
  localparam logic [3:0] SSpdM  = 4'd9;
  localparam logic [3:0] SSpd   = 4'd10;
  localparam logic [3:0] SDone  = 4'd11;

  // segment table
  logic [31:0] st_start_q  [ssg_pkg::MaxSegments];
  logic [31:0] st_target_q [ssg_pkg::MaxSegments];
  logic [31:0] st_span_q   [ssg_pkg::MaxSegments];
  logic [1:0]  st_shape_q  [ssg_pkg::MaxSegments];
  logic        st_dist_q   [ssg_pkg::MaxSegments];

  logic [3:0]  state_q, ret_q;
  logic [4:0]  seg_count_q;
  logic [4:0]  active_q;
  logic [31:0] time_q, dist_q;
  logic [31:0] t_left_q, d_left_q;
  logic [31:0] rem_q;
  logic [16:0] p_q;
  logic [16:0] f_q;
  logic [3:0]  cnt_q;
  logic [32:0] mul_a_q;
  logic [17:0] mul_b_q;
  logic [50:0] prod_q;
  logic        neg_q;
  logic [31:0] speed_q;

  // current segment view
  logic [4:0]  eff;
  logic [ssg_pkg::IdxW-1:0] k, last_k;
  logic [31:0] span, acc, num, room, left_v;
  logic        is_dist;
  logic [32:0] div_sh;
  logic [34:0] rnd;
  logic [ssg_pkg::CosIdxW-1:0] ci;
  logic [32:0] d_s;
  logic [33:0] spd_res;
  logic [32:0] r_v;

  assign eff     = (seg_count_q > 5'(ssg_pkg::MaxSegments)) ?
                   5'(ssg_pkg::MaxSegments) : seg_count_q;
  assign k       = active_q[ssg_pkg::IdxW-1:0];
  assign last_k  = ssg_pkg::IdxW'(eff - 5'd1);
  assign span    = st_span_q[k];
  assign is_dist = st_dist_q[k];
  assign acc     = is_dist ? dist_q : time_q;
  assign num     = acc;
  assign room    = (acc >= span) ? 32'd0 : span - acc;
  assign left_v  = is_dist ? d_left_q : t_left_q;
  assign div_sh  = {rem_q, 1'b0};
  assign rnd     = 35'((prod_q + 51'd32768) >> 16);
  assign ci      = p_q[16:8];
  assign d_s     = {st_target_q[k][31], st_target_q[k]} - {st_start_q[k][31], st_start_q[k]};
  assign r_v     = rnd[32:0];
  assign spd_res = neg_q ? {{2{st_start_q[k][31]}}, st_start_q[k]} - {1'b0, r_v}
                         : {{2{st_start_q[k][31]}}, st_start_q[k]} + {1'b0, r_v};

  // shared multiplier, registered product
  always_ff @(posedge clk_i) begin
    prod_q <= 51'(mul_a_q * mul_b_q);
  end

  // table writes
  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_valid_i && operation_i == ssg_pkg::OpLoad) begin
      st_start_q[slot_i]  <= start_speed_i;
      st_target_q[slot_i] <= target_speed_i;
      st_span_q[slot_i]   <= span_length_i;
      st_shape_q[slot_i]  <= shape_code_i;
      st_dist_q[slot_i]   <= distance_based_i;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= '0;
    end else if (cfg_we_i) begin
      seg_count_q <= cfg_wdata_i;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      ret_q    <= SIdle;
      active_q <= '0;
      time_q   <= '0;
      dist_q   <= '0;
    end else begin
      unique case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            t_left_q <= time_step_i[31] ? 32'd0 : time_step_i;
            d_left_q <= distance_step_i[31] ? 32'd0 : distance_step_i;
            if (operation_i == ssg_pkg::OpRestart) begin
              active_q <= '0;
              time_q   <= '0;
              dist_q   <= '0;
            end
            state_q <= (operation_i == ssg_pkg::OpAdvance) ? SWalk : SEval;
          end
        end
        SWalk: begin
          if (active_q >= eff) begin
            state_q <= SEval;
          end else if (span == 32'd0 || left_v >= room) begin
            if (span != 32'd0) begin
              if (is_dist) d_left_q <= d_left_q - room;
              else t_left_q <= t_left_q - room;
            end
            active_q <= active_q + 5'd1;
            time_q   <= '0;
            dist_q   <= '0;
          end else begin
            if (is_dist) dist_q <= acc + d_left_q;
            else time_q <= acc + t_left_q;
            state_q <= SEval;
          end
        end
        SEval: begin
          if (eff == 5'd0) begin
            speed_q <= '0;
            state_q <= SDone;
          end else if (active_q >= eff) begin
            speed_q <= st_target_q[last_k];
            state_q <= SDone;
          end else if (span == 32'd0) begin
            speed_q <= st_target_q[k];
            state_q <= SDone;
          end else if (num >= span) begin
            p_q     <= ssg_pkg::OneQ16;
            state_q <= SShape;
          end else begin
            rem_q   <= num;
            p_q     <= '0;
            cnt_q   <= '0;
            state_q <= SDiv;
          end
        end
        // restoring divide, one quotient bit per cycle
        SDiv: begin
          if (div_sh >= {1'b0, span}) begin
            rem_q <= 32'(div_sh - {1'b0, span});
            p_q   <= {p_q[15:0], 1'b1};
          end else begin
            rem_q <= div_sh[31:0];
            p_q   <= {p_q[15:0], 1'b0};
          end
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) state_q <= SShape;
        end
        SShape: begin
          unique case (st_shape_q[k])
            ssg_pkg::ShapeStep: begin
              f_q     <= (num != 32'd0) ? ssg_pkg::OneQ16 : 17'd0;
              state_q <= SSpdM;
            end
            ssg_pkg::ShapeLinear: begin
              f_q     <= p_q;
              state_q <= SSpdM;
            end
            ssg_pkg::ShapeSmooth: begin
              mul_a_q <= 33'(p_q);
              mul_b_q <= 18'(p_q);
              ret_q   <= SSm1;
              state_q <= SMul;
            end
            ssg_pkg::ShapeCosine: begin
              if (ci >= ssg_pkg::CosIdxW'(ssg_pkg::CosN)) begin
                f_q     <= ssg_pkg::CosRom[ssg_pkg::CosN];
                state_q <= SSpdM;
              end else begin
                f_q     <= ssg_pkg::CosRom[ci];
                mul_a_q <= 33'(ssg_pkg::CosRom[ci + 1'b1] - ssg_pkg::CosRom[ci]);
                mul_b_q <= {2'b00, p_q[7:0], 8'h00};
                ret_q   <= SCos;
                state_q <= SMul;
              end
            end
            default: state_q <= SSpdM;
          endcase
        end
        SMul: begin
          state_q <= ret_q;
        end
        SSm1: begin
          mul_a_q <= 33'(rnd[16:0]);
          mul_b_q <= 18'd196608 - {p_q, 1'b0};
          ret_q   <= SSm2;
          state_q <= SMul;
        end
        SSm2: begin
          f_q     <= (rnd > 35'(ssg_pkg::OneQ16)) ? ssg_pkg::OneQ16 : rnd[16:0];
          state_q <= SSpdM;
        end
        SCos: begin
          f_q     <= f_q + rnd[16:0];
          state_q <= SSpdM;
        end
        SSpdM: begin
          neg_q   <= d_s[32];
          mul_a_q <= d_s[32] ? 33'(-d_s) : d_s;
          mul_b_q <= 18'(f_q);
          ret_q   <= SSpd;
          state_q <= SMul;
        end
        SSpd: begin
          speed_q <= spd_res[31:0];
          state_q <= SDone;
        end
        SDone: begin
          if (!out_stall_i) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign in_stall_o      = (state_q != SIdle);
  assign out_valid_o     = (state_q == SDone);
  assign speed_out_o     = speed_q;
  assign finished_o      = (active_q >= eff);
  assign segment_index_o = active_q;

  // result beat never offered while a new beat can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o))
    else $error("result offered while idle");

  // an accepted beat makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("beat accepted but block not busy");

  // active index stays at most one past the last table entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q <= 5'(ssg_pkg::MaxSegments))
    else $error("active index out of range");

endmodule
